@@ sv/stt_pkg.sv @@
package stt_pkg;

    localparam int OFS_BITS    = 24;
    localparam int LC_BITS     = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_IDENT  = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_SYMBOL = 2'd3;

    // Byte classification carried from front to back.
    typedef struct packed {
        logic is_end;
        logic is_digit;
        logic is_letter;
        logic is_under;
        logic is_quote;
        logic is_bslash;
        logic is_newline;
        logic is_symbol;    // includes underscore and backslash
        logic esc_ok;       // quote, n, t or backslash after a backslash
    } byte_class_t;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_NUM   = 5'b00010,
        MODE_IDENT = 5'b00100,
        MODE_STR   = 5'b01000,
        MODE_SYM   = 5'b10000
    } lex_mode_t;

    function automatic logic [OFS_BITS-1:0] sat_inc_ofs(input logic [OFS_BITS-1:0] v);
        return (&v) ? v : v + OFS_BITS'(1);
    endfunction

    function automatic logic [LC_BITS-1:0] sat_inc_lc(input logic [LC_BITS-1:0] v);
        return (&v) ? v : v + LC_BITS'(1);
    endfunction

endpackage

@@ sv/stt_front.sv @@
module stt_front
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  source_byte,
    output logic        q_valid,
    output byte_class_t q_item,
    input  logic        q_pop
);

    byte_class_t cls;
    byte_class_t mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic push;
    logic pop;

    always_comb
    begin
        cls.is_end     = (source_byte == CH_END);
        cls.is_digit   = source_byte inside {[8'h30:8'h39]};
        cls.is_letter  = source_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
        cls.is_under   = (source_byte == CH_UNDERSCORE);
        cls.is_quote   = (source_byte == CH_QUOTE);
        cls.is_bslash  = (source_byte == CH_BACKSLASH);
        cls.is_newline = (source_byte == CH_NEWLINE);
        cls.is_symbol  = source_byte inside {8'h21, [8'h23:8'h26], [8'h28:8'h2F],
                                             [8'h3A:8'h40], [8'h5B:8'h60],
                                             [8'h7B:8'h7E]};
        cls.esc_ok     = (source_byte == CH_QUOTE) || (source_byte == CH_LOWER_N) ||
                         (source_byte == CH_LOWER_T) || (source_byte == CH_BACKSLASH);
    end

    assign in_stall = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ sv/stt_back.sv @@
module stt_back
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  byte_class_t         q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          token_kind,
    output logic [OFS_BITS-1:0] token_start,
    output logic [OFS_BITS-1:0] token_length,
    output logic [LC_BITS-1:0]  token_line,
    output logic [LC_BITS-1:0]  token_column,
    output logic                string_error
);

    lex_mode_t mode_reg, mode_next;
    logic esc_reg, esc_next;
    logic err_reg, err_next;
    logic [OFS_BITS-1:0] offset_reg, offset_next;
    logic [LC_BITS-1:0]  line_reg, line_next;
    logic [LC_BITS-1:0]  col_reg, col_next;
    logic [OFS_BITS-1:0] ostart_reg, ostart_next;
    logic [OFS_BITS-1:0] olen_reg, olen_next;
    logic [LC_BITS-1:0]  oline_reg, oline_next;
    logic [LC_BITS-1:0]  ocol_reg, ocol_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          kind_reg;
    logic [OFS_BITS-1:0] start_reg;
    logic [OFS_BITS-1:0] length_reg;
    logic [LC_BITS-1:0]  tline_reg;
    logic [LC_BITS-1:0]  tcol_reg;
    logic                serr_reg;

    logic                take;
    logic                emit;
    logic [OFS_BITS-1:0] emit_len;
    logic                emit_err;
    logic [1:0]          emit_kind;
    logic                extend;
    logic [OFS_BITS-1:0] len_inc;

    assign take  = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = take;
    assign len_inc = sat_inc_ofs(olen_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_NUM:   emit_kind = KIND_NUMBER;
            MODE_IDENT: emit_kind = KIND_IDENT;
            MODE_STR:   emit_kind = KIND_STRING;
            default:    emit_kind = KIND_SYMBOL;
        endcase
    end

    assign extend = ((mode_reg == MODE_NUM) && q_item.is_digit) ||
                    ((mode_reg == MODE_IDENT) &&
                     (q_item.is_digit || q_item.is_letter || q_item.is_under)) ||
                    ((mode_reg == MODE_SYM) && q_item.is_symbol);

    always_comb
    begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        err_next    = err_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        ostart_next = ostart_reg;
        olen_next   = olen_reg;
        oline_next  = oline_reg;
        ocol_next   = ocol_reg;
        emit        = 1'b0;
        emit_len    = olen_reg;
        emit_err    = 1'b0;

        if (take)
        begin
            if (q_item.is_end)
            begin
                emit        = (mode_reg != MODE_IDLE);
                emit_err    = (mode_reg == MODE_STR) && (err_reg || esc_reg);
                mode_next   = MODE_IDLE;
                esc_next    = 1'b0;
                err_next    = 1'b0;
                offset_next = '0;
                line_next   = LC_BITS'(1);
                col_next    = LC_BITS'(1);
                ostart_next = '0;
                olen_next   = '0;
                oline_next  = LC_BITS'(1);
                ocol_next   = LC_BITS'(1);
            end
            else if (mode_reg == MODE_STR)
            begin
                olen_next   = len_inc;
                offset_next = sat_inc_ofs(offset_reg);
                col_next    = sat_inc_lc(col_reg);
                if (esc_reg)
                begin
                    if (!q_item.esc_ok)
                    begin
                        err_next = 1'b1;
                    end
                    esc_next = 1'b0;
                end
                else if (q_item.is_quote)
                begin
                    // closing quote counts toward the length
                    emit      = 1'b1;
                    emit_len  = len_inc;
                    emit_err  = err_reg;
                    mode_next = MODE_IDLE;
                    esc_next  = 1'b0;
                    err_next  = 1'b0;
                end
                else if (q_item.is_bslash)
                begin
                    esc_next = 1'b1;
                end
                else if (q_item.is_newline)
                begin
                    err_next = 1'b1;
                end
            end
            else if (extend)
            begin
                olen_next   = len_inc;
                offset_next = sat_inc_ofs(offset_reg);
                col_next    = sat_inc_lc(col_reg);
            end
            else
            begin
                emit      = (mode_reg != MODE_IDLE);
                mode_next = MODE_IDLE;
                esc_next  = 1'b0;
                err_next  = 1'b0;
                offset_next = sat_inc_ofs(offset_reg);
                if (q_item.is_newline)
                begin
                    line_next = sat_inc_lc(line_reg);
                    col_next  = LC_BITS'(1);
                end
                else
                begin
                    col_next = sat_inc_lc(col_reg);
                    if (q_item.is_digit || q_item.is_letter || q_item.is_under ||
                        q_item.is_quote || q_item.is_symbol)
                    begin
                        ostart_next = offset_reg;
                        olen_next   = OFS_BITS'(1);
                        oline_next  = line_reg;
                        ocol_next   = col_reg;
                        if (q_item.is_digit)
                        begin
                            mode_next = MODE_NUM;
                        end
                        else if (q_item.is_letter || q_item.is_under)
                        begin
                            mode_next = MODE_IDENT;
                        end
                        else if (q_item.is_quote)
                        begin
                            mode_next = MODE_STR;
                        end
                        else
                        begin
                            mode_next = MODE_SYM;
                        end
                    end
                end
            end
        end
    end

    assign out_valid_next = take ? emit : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            esc_reg       <= 1'b0;
            err_reg       <= 1'b0;
            offset_reg    <= '0;
            line_reg      <= LC_BITS'(1);
            col_reg       <= LC_BITS'(1);
            ostart_reg    <= '0;
            olen_reg      <= '0;
            oline_reg     <= LC_BITS'(1);
            ocol_reg      <= LC_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            esc_reg       <= esc_next;
            err_reg       <= err_next;
            offset_reg    <= offset_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            ostart_reg    <= ostart_next;
            olen_reg      <= olen_next;
            oline_reg     <= oline_next;
            ocol_reg      <= ocol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg   <= emit_kind;
            start_reg  <= ostart_reg;
            length_reg <= emit_len;
            tline_reg  <= oline_reg;
            tcol_reg   <= ocol_reg;
            serr_reg   <= emit_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign token_start  = start_reg;
    assign token_length = length_reg;
    assign token_line   = tline_reg;
    assign token_column = tcol_reg;
    assign string_error = serr_reg;

endmodule

@@ sv/source_text_tokenizer.sv @@
// Streaming tokenizer: one source byte per word in, at most one token per word out.
// It sustains one byte per clock while the queue has room; a byte reaches the two-entry
// queue at the edge it is taken, and the lexer state machine in the back end handles
// one byte per clock unless its output stalls, so a token is loaded into the output
// register when the lexer takes the byte ending it from the queue. A zero byte flushes
// any open token and returns offset, line and column to their start values. Offset,
// length, line and column saturate at all ones. A stalled output holds the lexer; the
// queue keeps taking bytes until it is full.
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          source_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          token_kind,
    output logic [OFS_BITS-1:0] token_start,
    output logic [OFS_BITS-1:0] token_length,
    output logic [LC_BITS-1:0]  token_line,
    output logic [LC_BITS-1:0]  token_column,
    output logic                string_error
);

    logic        q_valid;
    logic        q_pop;
    byte_class_t q_item;

    stt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .source_byte (source_byte),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    stt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .token_column (token_column),
        .string_error (string_error)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench
    import stt_pkg::*;
();

    typedef struct packed {
        logic [1:0]          kind;
        logic [OFS_BITS-1:0] start;
        logic [OFS_BITS-1:0] length;
        logic [LC_BITS-1:0]  line;
        logic [LC_BITS-1:0]  column;
        logic                err;
    } token_t;

    class token_scoreboard;
        token_t expected_tokens[$];
        int     fail_count;
        int     bytes_seen;
        int     tokens_checked;
        int     strings_checked;
        int     strings_flagged;

        // lexer state as the block should hold it
        lex_mode_t           mode;
        bit                  esc_pending;
        bit                  err_seen;
        logic [OFS_BITS-1:0] offset;
        logic [LC_BITS-1:0]  line;
        logic [LC_BITS-1:0]  column;
        logic [OFS_BITS-1:0] open_start;
        logic [OFS_BITS-1:0] open_len;
        logic [LC_BITS-1:0]  open_line;
        logic [LC_BITS-1:0]  open_column;

        function new();
            clear_state();
        endfunction

        function void clear_state();
            mode        = MODE_IDLE;
            esc_pending = 0;
            err_seen    = 0;
            offset      = '0;
            line        = LC_BITS'(1);
            column      = LC_BITS'(1);
            open_start  = '0;
            open_len    = '0;
            open_line   = LC_BITS'(1);
            open_column = LC_BITS'(1);
        endfunction

        function logic [OFS_BITS-1:0] bump_ofs(logic [OFS_BITS-1:0] v);
            return (v == {OFS_BITS{1'b1}}) ? v : v + OFS_BITS'(1);
        endfunction

        function logic [LC_BITS-1:0] bump_lc(logic [LC_BITS-1:0] v);
            return (v == {LC_BITS{1'b1}}) ? v : v + LC_BITS'(1);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        // printable punctuation except the two quote marks
        function bit is_symbol(logic [7:0] c);
            return (c >= 8'h21 && c <= 8'h2F && c != CH_QUOTE && c != 8'h27) ||
                   (c >= 8'h3A && c <= 8'h40) || (c >= 8'h5B && c <= 8'h60) ||
                   (c >= 8'h7B && c <= 8'h7E);
        endfunction

        function void step_position();
            offset = bump_ofs(offset);
            column = bump_lc(column);
        endfunction

        function void open_token(lex_mode_t m);
            mode        = m;
            open_start  = offset;
            open_len    = OFS_BITS'(1);
            open_line   = line;
            open_column = column;
            esc_pending = 0;
            err_seen    = 0;
        endfunction

        function token_t close_token();
            token_t t;
            case (mode)
                MODE_NUM:   t.kind = KIND_NUMBER;
                MODE_IDENT: t.kind = KIND_IDENT;
                MODE_STR:   t.kind = KIND_STRING;
                default:    t.kind = KIND_SYMBOL;
            endcase
            t.start  = open_start;
            t.length = open_len;
            t.line   = open_line;
            t.column = open_column;
            t.err    = (mode == MODE_STR) ? err_seen : 1'b0;
            mode        = MODE_IDLE;
            esc_pending = 0;
            err_seen    = 0;
            return t;
        endfunction

        // accepted input word: advance the lexer and queue any finished token
        function void note_byte(logic [7:0] c);
            token_t t;
            bit     done;
            done = 0;
            bytes_seen++;
            if (c == CH_END)
            begin
                if (mode != MODE_IDLE)
                begin
                    if (mode == MODE_STR && esc_pending)
                        err_seen = 1;
                    t    = close_token();
                    done = 1;
                end
                clear_state();
            end
            else if (mode == MODE_STR)
            begin
                open_len = bump_ofs(open_len);
                if (esc_pending)
                begin
                    if (c != CH_QUOTE && c != CH_LOWER_N &&
                        c != CH_LOWER_T && c != CH_BACKSLASH)
                        err_seen = 1;
                    esc_pending = 0;
                end
                else if (c == CH_QUOTE)
                begin
                    t    = close_token();
                    done = 1;
                end
                else if (c == CH_BACKSLASH)
                    esc_pending = 1;
                else if (c == CH_NEWLINE)
                    err_seen = 1;   // line counter stays put inside a string
                step_position();
            end
            else if ((mode == MODE_NUM && is_digit(c)) ||
                     (mode == MODE_IDENT &&
                      (c == CH_UNDERSCORE || is_letter(c) || is_digit(c))) ||
                     (mode == MODE_SYM && is_symbol(c)))
            begin
                open_len = bump_ofs(open_len);
                step_position();
            end
            else
            begin
                // ending byte closes the open token, then starts fresh
                if (mode != MODE_IDLE)
                begin
                    t    = close_token();
                    done = 1;
                end
                if (c == CH_NEWLINE)
                begin
                    offset = bump_ofs(offset);
                    line   = bump_lc(line);
                    column = LC_BITS'(1);
                end
                else
                begin
                    if (is_digit(c))
                        open_token(MODE_NUM);
                    else if (c == CH_UNDERSCORE || is_letter(c))
                        open_token(MODE_IDENT);
                    else if (c == CH_QUOTE)
                        open_token(MODE_STR);
                    else if (is_symbol(c))
                        open_token(MODE_SYM);
                    step_position();
                end
            end
            if (done)
                expected_tokens.insert(expected_tokens.size(), t);
        endfunction

        function void mismatch(string field, logic [31:0] exp, logic [31:0] act);
            $display("%0t: token %0d %s mismatch: expected %0d, got %0d",
                     $time, tokens_checked, field, exp, act);
            fail_count++;
        endfunction

        function void check_token(token_t got);
            token_t exp;
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token kind %0d start %0d length %0d",
                         $time, got.kind, got.start, got.length);
                fail_count++;
                return;
            end
            exp = expected_tokens.pop_front();
            if (got.kind !== exp.kind)
                mismatch("kind", exp.kind, got.kind);
            if (got.start !== exp.start)
                mismatch("start", exp.start, got.start);
            if (got.length !== exp.length)
                mismatch("length", exp.length, got.length);
            if (got.line !== exp.line)
                mismatch("line", exp.line, got.line);
            if (got.column !== exp.column)
                mismatch("column", exp.column, got.column);
            if (got.err !== exp.err)
                mismatch("string_error", exp.err, got.err);
            if (exp.kind == KIND_STRING)
            begin
                strings_checked++;
                if (exp.err)
                    strings_flagged++;
            end
            tokens_checked++;
        endfunction
    endclass

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_RETURN = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam int         RANDOM_BYTES = 1300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          source_byte = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          token_kind;
    logic [OFS_BITS-1:0] token_start;
    logic [OFS_BITS-1:0] token_length;
    logic [LC_BITS-1:0]  token_line;
    logic [LC_BITS-1:0]  token_column;
    logic                string_error;

    token_scoreboard sb = new();

    int    sent_bytes = 0;
    int    hold_cycles = 0;
    bit    send_quiet = 0;
    bit    recv_quiet = 0;
    string name_chars = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string symbol_chars = "!#$%&()*+,-./:;<=>?@[\\]^_`{|}~";

    source_text_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_byte  (source_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .token_line   (token_line),
        .token_column (token_column),
        .string_error (string_error)
    );

    always #5 clk = ~clk;

    // quiet runs switch on and off now and then: no idling while on
    function automatic int pick_wait(inout bit quiet);
        if ($urandom_range(0, 49) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_byte(source_byte);
    end

    always @(posedge clk)
    begin : watch_tokens
        token_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind   = token_kind;
            got.start  = token_start;
            got.length = token_length;
            got.line   = token_line;
            got.column = token_column;
            got.err    = string_error;
            sb.check_token(got);
        end
    end

    initial
    begin : receiver
        int w;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                w = hold_cycles;
                hold_cycles = 0;
            end
            else
                w = pick_wait(recv_quiet);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_byte(logic [7:0] b);
        int w;
        w = pick_wait(send_quiet);
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid    <= 1'b1;
        source_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_fragment();
        int          pick;
        int          len;
        int          i;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            send_byte(name_chars[$urandom_range(0, 52)]);
            len = $urandom_range(0, 8);
            for (i = 0; i < len; i++)
                send_byte(name_chars[$urandom_range(0, name_chars.len() - 1)]);
        end
        else if (pick < 35)
        begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
                send_byte(8'h30 + 8'($urandom_range(0, 9)));
        end
        else if (pick < 50)
        begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++)
                send_byte(symbol_chars[$urandom_range(0, symbol_chars.len() - 1)]);
        end
        else if (pick < 68)
        begin
            send_byte(CH_QUOTE);
            len = $urandom_range(0, 8);
            for (i = 0; i < len; i++)
            begin
                c = 8'($urandom_range(0, 19));
                if (c < 2)
                begin
                    send_byte(CH_BACKSLASH);
                    case ($urandom_range(0, 4))
                        0: send_byte(CH_QUOTE);
                        1: send_byte(CH_LOWER_N);
                        2: send_byte(CH_LOWER_T);
                        3: send_byte(CH_BACKSLASH);
                        default: send_byte(8'($urandom_range(1, 255)));
                    endcase
                end
                else if (c == 2)
                    send_byte(CH_NEWLINE);
                else
                    send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
            len = $urandom_range(0, 99);
            if (len < 88)
                send_byte(CH_QUOTE);
            else if (len < 92)
            begin
                // source ends right after a backslash
                send_byte(CH_BACKSLASH);
                send_byte(CH_END);
            end
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(CH_SPACE);
                1: send_byte(CH_NEWLINE);
                2: send_byte(CH_RETURN);
                default: send_byte(CH_TAB);
            endcase
        end
        else if (pick < 98)
            send_byte(8'($urandom_range(1, 255)));
        else
            send_byte(CH_END);
    endtask

    initial
    begin : stimulus
        bit held;
        int drain;
        held = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // names, numbers, symbol run with underscore, escapes, newline in string
        send_text("_a1 42+_-\n\"\\n\\q\n\"\r");
        send_byte(8'h80);
        send_byte(8'hFF);
        // open string with a trailing backslash cut by end of source
        send_text("'x\"\\");
        send_byte(CH_END);
        send_byte(CH_END);
        send_text("9");
        send_byte(CH_END);

        while (sent_bytes < RANDOM_BYTES)
        begin
            if (!held && sent_bytes > RANDOM_BYTES / 2)
            begin
                // long receiver hold-off while bytes keep coming
                hold_cycles = 400;
                send_quiet  = 1;
                held        = 1;
            end
            send_fragment();
        end
        send_byte(CH_END);
        in_valid <= 1'b0;

        drain = 0;
        while (sb.expected_tokens.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (30) @(posedge clk);
        if (sb.expected_tokens.size() != 0)
        begin
            $display("%0t: %0d expected tokens never arrived, next kind %0d start %0d",
                     $time, sb.expected_tokens.size(), sb.expected_tokens[0].kind,
                     sb.expected_tokens[0].start);
            sb.fail_count++;
        end

        $display("Run covered %0d source bytes and %0d tokens,", sb.bytes_seen,
                 sb.tokens_checked);
        $display("of them %0d strings (%0d with a bad escape or raw newline).",
                 sb.strings_checked, sb.strings_flagged);
        if (sb.fail_count == 0)
            $display("PASS source_text_tokenizer");
        else
            $display("FAIL source_text_tokenizer");
        $finish;
    end

    initial
    begin : watchdog
        #4ms;
        $display("%0t: timeout", $time);
        $display("FAIL source_text_tokenizer");
        $finish;
    end

endmodule
